/* src/wfr_pkg.sv */
// Package for the WAKE frame receiver: frame marker bytes, the CRC-8 step
// and the structs that pass between the parser and the top level.
// Depends on nothing.
package wfr_pkg;

   localparam logic [7:0] MARK_END   = 8'hC0;
   localparam logic [7:0] MARK_ESC   = 8'hDB;
   localparam logic [7:0] MARK_T_END = 8'hDC;
   localparam logic [7:0] MARK_T_ESC = 8'hDD;
   localparam int         MAX_RUN    = 32;

   localparam logic [1:0] CSR_OWN_ADDRESS = 2'd0;
   localparam logic [1:0] CSR_CRC_SEED    = 2'd1;
   localparam logic [1:0] CSR_CRC_POLY    = 2'd2;

   typedef struct packed {
      logic [6:0] own_address;
      logic [7:0] crc_seed;
      logic [7:0] crc_poly;
   } cfg_type;

   typedef struct packed {
      logic       en;
      logic [5:0] index;
      logic [7:0] data;
   } store_wr_type;

   typedef struct packed {
      logic       start;
      logic [6:0] address;
      logic [6:0] command;
      logic [5:0] length;
   } frame_hdr_type;

   function automatic logic [7:0] crc8_take(input logic [7:0] crc, input logic [7:0] b,
                                            input logic [7:0] poly);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
      end
      return c;
   endfunction

endpackage

/* src/wake_frame_receiver.sv */
// Top level of the WAKE frame receiver: configuration registers, payload
// store and readout sequencer. Depends on wfr_pkg and wfr_frame_parser.
//
//   Channel  Direction  Handshake               Payload
//   req_     in         req_tvalid/req_tready   tdata: rx_byte
//   rsp_     out        rsp_tvalid/rsp_tready   tdata, tuser, tlast
//   csr_     in         csr_valid/csr_ready     csr_index, csr_data
//
// The parser accepts one byte per cycle while req_tready is high, that is while
// no readout runs. After a good CRC byte the block stops taking bytes and reads
// the payload store out, each result through a store read and then the output
// register, and holds a result while rsp_tready is low. Reset is synchronous and
// clears all control state; the payload store is not cleared.
module wake_frame_receiver #(
   parameter int BUF_BYTES = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [6:0] frame_address, [13:7] frame_command,
                                    // [19:14] frame_length, [28:21] payload_byte
   output logic        rsp_tuser,   // [0] payload_valid
   output logic        rsp_tlast,   // last_of_frame
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);
   import wfr_pkg::*;

   localparam int ADDR_W = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1;

   typedef enum logic [1:0] {
      RD_IDLE,
      RD_READ,
      RD_SHOW
   } rd_state_type;

   cfg_type       cfg_ff;
   store_wr_type  wr;
   frame_hdr_type hdr;
   rd_state_type  state_ff;
   logic [5:0]    ptr_ff;
   logic          empty_ff;
   logic [7:0]    store_q_ff;
   logic [7:0]    store [BUF_BYTES];
   logic          take;
   logic          last;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == RD_IDLE);
   assign take       = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.own_address <= 7'd1;
         cfg_ff.crc_seed    <= 8'hDE;
         cfg_ff.crc_poly    <= 8'h8C;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_OWN_ADDRESS: cfg_ff.own_address <= csr_data[6:0];
            CSR_CRC_SEED:    cfg_ff.crc_seed    <= csr_data;
            CSR_CRC_POLY:    cfg_ff.crc_poly    <= csr_data;
            default:         ;
         endcase
      end
   end

   wfr_frame_parser #(
      .BUF_BYTES(BUF_BYTES)
   ) u_parser (
      .clock  (clock),
      .reset  (reset),
      .take   (take),
      .rx_byte(req_tdata),
      .cfg    (cfg_ff),
      .wr     (wr),
      .hdr    (hdr)
   );

   always_ff @(posedge clock) begin
      if (wr.en) begin
         store[wr.index[ADDR_W-1:0]] <= wr.data;
      end
      store_q_ff <= store[ptr_ff[ADDR_W-1:0]];
   end

   assign last = empty_ff || (ptr_ff == hdr.length - 6'd1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= RD_IDLE;
         ptr_ff   <= 6'd0;
         empty_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            RD_IDLE: begin
               if (hdr.start) begin
                  ptr_ff   <= 6'd0;
                  empty_ff <= (hdr.length == 6'd0);
                  state_ff <= (hdr.length == 6'd0) ? RD_SHOW : RD_READ;
               end
            end
            RD_READ: state_ff <= RD_SHOW;
            RD_SHOW: begin
               if (rsp_tready) begin
                  if (last) begin
                     state_ff <= RD_IDLE;
                  end else begin
                     ptr_ff   <= ptr_ff + 6'd1;
                     state_ff <= RD_READ;
                  end
               end
            end
            default: state_ff <= RD_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = (state_ff == RD_SHOW);
   assign rsp_tuser  = !empty_ff;
   assign rsp_tlast  = last;
   assign rsp_tdata  = {3'd0, empty_ff ? 8'd0 : store_q_ff, 1'b0, hdr.length,
                        hdr.command, hdr.address};

endmodule

/* src/wfr_frame_parser.sv */
// Byte parser of the WAKE frame receiver: unescaping, header checks, CRC-8
// and store writes. Depends on wfr_pkg.
module wfr_frame_parser #(
   parameter int BUF_BYTES = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   take,
   input  logic [7:0]             rx_byte,
   input  wfr_pkg::cfg_type       cfg,
   output wfr_pkg::store_wr_type  wr,
   output wfr_pkg::frame_hdr_type hdr
);
   import wfr_pkg::*;

   localparam int LEN_LIMIT = (BUF_BYTES < MAX_RUN) ? BUF_BYTES : MAX_RUN;

   typedef enum logic [2:0] {
      PH_WAIT,
      PH_ADDR,
      PH_CMD,
      PH_LEN,
      PH_DATA
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic       esc_ff, esc_in;
   logic [7:0] crc_ff, crc_in;
   logic [6:0] addr_ff, addr_in;
   logic [6:0] cmd_ff, cmd_in;
   logic [5:0] len_ff, len_in;
   logic [5:0] count_ff, count_in;
   logic [7:0] d;
   logic       bad_esc;
   logic       start;
   logic       wr_en;

   always_comb begin
      phase_in = phase_ff;
      esc_in   = esc_ff;
      crc_in   = crc_ff;
      addr_in  = addr_ff;
      cmd_in   = cmd_ff;
      len_in   = len_ff;
      count_in = count_ff;
      start    = 1'b0;
      wr_en    = 1'b0;
      bad_esc  = 1'b0;
      d        = rx_byte;
      if (esc_ff) begin
         priority if (rx_byte == MARK_T_ESC) begin
            d = MARK_ESC;
         end else if (rx_byte == MARK_T_END) begin
            d = MARK_END;
         end else begin
            bad_esc = 1'b1;
         end
      end
      if (take) begin
         priority if (rx_byte == MARK_END) begin
            esc_in   = 1'b0;
            crc_in   = crc8_take(cfg.crc_seed, MARK_END, cfg.crc_poly);
            phase_in = PH_ADDR;
         end else if (phase_ff == PH_WAIT) begin
            phase_in = PH_WAIT;
         end else if (bad_esc) begin
            esc_in   = (rx_byte == MARK_ESC);
            phase_in = PH_WAIT;
         end else if (!esc_ff && rx_byte == MARK_ESC) begin
            esc_in = 1'b1;
         end else begin
            esc_in = 1'b0;
            unique case (phase_ff)
               PH_ADDR: begin
                  if (d[7]) begin
                     crc_in = crc8_take(crc_ff, d, cfg.crc_poly);
                     if (d[6:0] == 7'd0 || d[6:0] == cfg.own_address) begin
                        addr_in  = d[6:0];
                        phase_in = PH_CMD;
                     end else begin
                        phase_in = PH_WAIT;
                     end
                  end else begin
                     addr_in  = 7'd0;
                     cmd_in   = d[6:0];
                     crc_in   = crc8_take(crc_ff, d, cfg.crc_poly);
                     phase_in = PH_LEN;
                  end
               end
               PH_CMD: begin
                  if (d[7]) begin
                     phase_in = PH_WAIT;
                  end else begin
                     cmd_in   = d[6:0];
                     crc_in   = crc8_take(crc_ff, d, cfg.crc_poly);
                     phase_in = PH_LEN;
                  end
               end
               PH_LEN: begin
                  if (d > 8'(LEN_LIMIT)) begin
                     phase_in = PH_WAIT;
                  end else begin
                     len_in   = d[5:0];
                     crc_in   = crc8_take(crc_ff, d, cfg.crc_poly);
                     count_in = 6'd0;
                     phase_in = PH_DATA;
                  end
               end
               PH_DATA: begin
                  if (count_ff < len_ff) begin
                     wr_en    = 1'b1;
                     count_in = count_ff + 6'd1;
                     crc_in   = crc8_take(crc_ff, d, cfg.crc_poly);
                  end else begin
                     phase_in = PH_WAIT;
                     start    = (d == crc_ff);
                  end
               end
               default: phase_in = PH_WAIT;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT;
         esc_ff   <= 1'b0;
         crc_ff   <= 8'd0;
         addr_ff  <= 7'd0;
         cmd_ff   <= 7'd0;
         len_ff   <= 6'd0;
         count_ff <= 6'd0;
      end else begin
         phase_ff <= phase_in;
         esc_ff   <= esc_in;
         crc_ff   <= crc_in;
         addr_ff  <= addr_in;
         cmd_ff   <= cmd_in;
         len_ff   <= len_in;
         count_ff <= count_in;
      end
   end

   assign wr.en       = wr_en;
   assign wr.index    = count_ff;
   assign wr.data     = d;
   assign hdr.start   = start;
   assign hdr.address = addr_ff;
   assign hdr.command = cmd_ff;
   assign hdr.length  = len_ff;

endmodule

/* src/wfr_checker.sv */
// Port-level checker for the WAKE frame receiver, bound to the top level.
// Depends only on the top level's ports.
module wfr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);

   // No byte is taken while a result item is on offer.
   assert property (@(posedge clock) disable iff (reset) rsp_tvalid |-> !req_tready)
      else $error("input accepted during readout");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result item changed");

   // An empty frame is one item with zero length and zero payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast && rsp_tdata[28:14] == 15'd0)
      else $error("bad empty-frame item");

   // After the last item of a run a new run needs a fresh frame first.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> !rsp_tvalid)
      else $error("result item directly after end of run");

endmodule

bind wake_frame_receiver wfr_checker u_wfr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tuser (rsp_tuser),
   .rsp_tlast (rsp_tlast)
);
